/* rtl/core/tmcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared types and constants of the text mode console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

    localparam int POS_W    = 11;
    localparam int CELL_W   = 16;
    localparam int CHAR_W   = 8;
    localparam int RADDR_W  = 11;
    localparam int CMD_W    = 2;
    localparam int CFG_W    = 4;
    localparam int CFG_IDX_W = 1;
    localparam int QDEPTH   = 2;   // power of two

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    localparam logic [CFG_W-1:0] FG_RESET = 4'd7;
    localparam logic [CFG_W-1:0] BG_RESET = 4'd0;
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_PUT       = 3'd0;
    localparam logic [OP_W-1:0] OP_NEWLINE   = 3'd1;
    localparam logic [OP_W-1:0] OP_BACKSPACE = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd3;
    localparam logic [OP_W-1:0] OP_READ      = 3'd4;
    localparam logic [OP_W-1:0] OP_NOP       = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]    kind;
        logic [CHAR_W-1:0]  char_code;
        logic [RADDR_W-1:0] addr;
    } op_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

endpackage

/* rtl/core/tmcw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tmcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/tmcw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_front
// Accepts input items and sorts them into operations for the back end.
// ----------------------------------------------------------------------------
module tmcw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tmcw_pkg::CMD_W-1:0]    cmd,
    input  logic [tmcw_pkg::CHAR_W-1:0]   char_code,
    input  logic [tmcw_pkg::RADDR_W-1:0]  read_address,
    input  tmcw_pkg::queue_status_t       q_status,
    input  logic                          init_busy,
    output logic                          push,
    output tmcw_pkg::op_t                 push_op
);
    import tmcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;

    logic in_range;

    assign in_stall = q_status.full || init_busy;
    assign push     = in_valid && !in_stall;
    assign in_range = (32'(read_address) < 32'(CELLS));

    always_comb
    begin
        push_op.char_code = char_code;
        push_op.addr      = read_address;
        case (cmd)
            CMD_PUT:
            begin
                if (char_code == CH_NEWLINE)
                begin
                    push_op.kind = OP_NEWLINE;
                end
                else if (char_code == CH_BACKSPACE)
                begin
                    push_op.kind = OP_BACKSPACE;
                end
                else
                begin
                    push_op.kind = OP_PUT;
                end
            end
            CMD_CLEAR: push_op.kind = OP_CLEAR;
            CMD_READ:  push_op.kind = in_range ? OP_READ : OP_NOP;
            default:   push_op.kind = OP_NOP;
        endcase
    end

endmodule

/* rtl/core/tmcw_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_queue
// Short operation queue between the front and back ends.
// ----------------------------------------------------------------------------
module tmcw_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  tmcw_pkg::op_t           push_op,
    input  logic                    pop,
    output tmcw_pkg::op_t           head_op,
    output tmcw_pkg::queue_status_t status
);
    import tmcw_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    op_t          entry_reg [QDEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    assign head_op      = entry_reg[rd_ptr_reg];
    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == (PW+1)'(QDEPTH));

endmodule

/* rtl/core/tmcw_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_back
// Executes operations: cursor update, screen store access, scroll and clear
// sweeps, and the result register.
// ----------------------------------------------------------------------------
module tmcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tmcw_pkg::queue_status_t           q_status,
    input  tmcw_pkg::op_t                     q_op,
    output logic                              q_pop,
    input  logic [2*tmcw_pkg::CFG_W-1:0]      attr,
    output logic                              init_busy,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tmcw_pkg::POS_W-1:0]        cursor_position,
    output logic [tmcw_pkg::CELL_W-1:0]       cell_data,
    output logic                              scrolled
);
    import tmcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_COPY   = 3'd2;
    localparam logic [2:0] ST_BLANK  = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [AW-1:0]     base_reg, base_next;
    logic              init_reg, init_next;
    logic              cp_pend_reg, cp_pend_next;
    logic [AW-1:0]     cp_addr_reg, cp_addr_next;
    logic [CELL_W-1:0] res_data_reg, res_data_next;
    logic              res_scroll_reg, res_scroll_next;
    logic              out_valid_reg, out_valid_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic [CELL_W-1:0] out_data_reg, out_data_next;
    logic              out_scroll_reg, out_scroll_next;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [CELL_W-1:0] wdata;
    logic [AW-1:0]     raddr;
    logic [CELL_W-1:0] rdata;

    logic [CELL_W-1:0] blank;
    logic [AW-1:0]     cur_addr;
    logic              out_free;
    logic              last_row;
    logic              last_col;
    logic [RW-1:0]     bs_row;
    logic [CW-1:0]     bs_col;
    logic [AW-1:0]     bs_base;

    tmcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign blank    = {attr, CH_SPACE};
    assign cur_addr = base_reg + AW'(col_reg);
    assign out_free = !out_valid_reg || !out_stall;
    assign last_row = (row_reg == RW'(ROWS - 1));
    assign last_col = (col_reg == CW'(COLUMNS - 1));

    always_comb
    begin
        bs_row  = row_reg;
        bs_col  = col_reg;
        bs_base = base_reg;
        if (col_reg != '0)
        begin
            bs_col = col_reg - 1'b1;
        end
        else if (row_reg != '0)
        begin
            bs_row  = row_reg - 1'b1;
            bs_col  = CW'(COLUMNS - 1);
            bs_base = base_reg - AW'(COLUMNS);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        base_next       = base_reg;
        init_next       = init_reg;
        cp_pend_next    = 1'b0;
        cp_addr_next    = cp_addr_reg;
        res_data_next   = res_data_reg;
        res_scroll_next = res_scroll_reg;
        out_valid_next  = out_valid_reg;
        out_pos_next    = out_pos_reg;
        out_data_next   = out_data_reg;
        out_scroll_next = out_scroll_reg;
        q_pop           = 1'b0;
        we              = 1'b0;
        waddr           = cur_addr;
        wdata           = blank;
        raddr           = AW'(q_op.addr);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // pending scroll copy write has the write port first
        if (cp_pend_reg)
        begin
            we    = 1'b1;
            waddr = cp_addr_reg;
            wdata = rdata;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (q_status.valid)
                begin
                    q_pop           = 1'b1;
                    res_data_next   = '0;
                    res_scroll_next = 1'b0;
                    state_next      = ST_RESULT;
                    case (q_op.kind)
                        OP_PUT:
                        begin
                            we            = 1'b1;
                            waddr         = cur_addr;
                            wdata         = {attr, q_op.char_code};
                            res_data_next = {attr, q_op.char_code};
                            if (last_col)
                            begin
                                col_next = '0;
                                if (last_row)
                                begin
                                    res_scroll_next = 1'b1;
                                    sweep_next      = AW'(COLUMNS);
                                    state_next      = ST_COPY;
                                end
                                else
                                begin
                                    row_next  = row_reg + 1'b1;
                                    base_next = base_reg + AW'(COLUMNS);
                                end
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                        OP_NEWLINE:
                        begin
                            col_next = '0;
                            if (last_row)
                            begin
                                res_scroll_next = 1'b1;
                                sweep_next      = AW'(COLUMNS);
                                state_next      = ST_COPY;
                            end
                            else
                            begin
                                row_next  = row_reg + 1'b1;
                                base_next = base_reg + AW'(COLUMNS);
                            end
                        end
                        OP_BACKSPACE:
                        begin
                            row_next      = bs_row;
                            col_next      = bs_col;
                            base_next     = bs_base;
                            we            = 1'b1;
                            waddr         = bs_base + AW'(bs_col);
                            wdata         = blank;
                            res_data_next = blank;
                        end
                        OP_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            base_next  = '0;
                            sweep_next = '0;
                            state_next = ST_FILL;
                        end
                        OP_READ:
                        begin
                            raddr      = AW'(q_op.addr);
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_data_next = rdata;
                state_next    = ST_RESULT;
            end
            ST_COPY:
            begin
                raddr        = sweep_reg;
                cp_pend_next = 1'b1;
                cp_addr_next = sweep_reg - AW'(COLUMNS);
                if (sweep_reg == AW'(CELLS - 1))
                begin
                    sweep_next = AW'((ROWS - 1) * COLUMNS);
                    state_next = ST_BLANK;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_BLANK:
            begin
                if (!cp_pend_reg)
                begin
                    we    = 1'b1;
                    waddr = sweep_reg;
                    wdata = blank;
                    if (sweep_reg == AW'(CELLS - 1))
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        sweep_next = sweep_reg + 1'b1;
                    end
                end
            end
            ST_FILL:
            begin
                we    = 1'b1;
                waddr = sweep_reg;
                wdata = init_reg ? RESET_CELL : blank;
                if (sweep_reg == AW'(CELLS - 1))
                begin
                    init_next  = 1'b0;
                    state_next = init_reg ? ST_IDLE : ST_RESULT;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_pos_next    = POS_W'(cur_addr);
                    out_data_next   = res_data_reg;
                    out_scroll_next = res_scroll_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            sweep_reg     <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            init_reg      <= 1'b1;
            cp_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            base_reg      <= base_next;
            init_reg      <= init_next;
            cp_pend_reg   <= cp_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_addr_reg    <= cp_addr_next;
        res_data_reg   <= res_data_next;
        res_scroll_reg <= res_scroll_next;
        out_pos_reg    <= out_pos_next;
        out_data_reg   <= out_data_next;
        out_scroll_reg <= out_scroll_next;
    end

    assign init_busy       = init_reg;
    assign out_valid       = out_valid_reg;
    assign cursor_position = out_pos_reg;
    assign cell_data       = out_data_reg;
    assign scrolled        = out_scroll_reg;

endmodule

/* rtl/core/text_mode_console_writer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_console_writer_top
// Character terminal over a ROWS x COLUMNS screen store of 16-bit cells.
//
//   channel | handshake         | payload
//   --------+-------------------+-------------------------------------------
//   in      | in_valid/in_stall | cmd, char_code, read_address
//   out     | out_valid/out_stall | cursor_position, cell_data, scrolled
//   cfg     | cfg_write         | cfg_index, cfg_data
//
// In the back end, put, newline, backspace and out-of-range reads go from idle
// straight to the result state; a read passes a read state first, a clear a
// fill sweep, and a put or newline that scrolls a copy sweep then a blank
// sweep: the screen RAM moves one cell per cycle on its single write port.
// A two-item queue sits ahead of the back end. After reset a clearing pass
// fills the screen; in_stall stays high meanwhile. A stalled result holds in
// the output register while the queue takes items until it is full.
// ----------------------------------------------------------------------------
module text_mode_console_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [tmcw_pkg::CMD_W-1:0]       cmd,
    input  logic [tmcw_pkg::CHAR_W-1:0]      char_code,
    input  logic [tmcw_pkg::RADDR_W-1:0]     read_address,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [tmcw_pkg::POS_W-1:0]       cursor_position,
    output logic [tmcw_pkg::CELL_W-1:0]      cell_data,
    output logic                             scrolled,
    input  logic                             cfg_write,
    input  logic [tmcw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tmcw_pkg::CFG_W-1:0]       cfg_data
);
    import tmcw_pkg::*;

    logic [CFG_W-1:0] fg_reg, fg_next;
    logic [CFG_W-1:0] bg_reg, bg_next;
    logic             push;
    op_t              push_op;
    op_t              head_op;
    logic             pop;
    queue_status_t    q_status;
    logic             init_busy;

    always_comb
    begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_FG:  fg_next = cfg_data;
                CFG_BG:  bg_next = cfg_data;
                default: fg_next = fg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= FG_RESET;
            bg_reg <= BG_RESET;
        end
        else
        begin
            fg_reg <= fg_next;
            bg_reg <= bg_next;
        end
    end

    tmcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .char_code    (char_code),
        .read_address (read_address),
        .q_status     (q_status),
        .init_busy    (init_busy),
        .push         (push),
        .push_op      (push_op)
    );

    tmcw_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .status  (q_status)
    );

    tmcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_status        (q_status),
        .q_op            (head_op),
        .q_pop           (pop),
        .attr            ({bg_reg, fg_reg}),
        .init_busy       (init_busy),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cursor_position (cursor_position),
        .cell_data       (cell_data),
        .scrolled        (scrolled)
    );

`ifndef SYNTHESIS
    a_no_result_during_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> !out_valid)
        else $error("result produced during clearing pass");

    a_pos_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(cursor_position) < 32'(ROWS * COLUMNS)))
        else $error("cursor position beyond screen");

    a_scroll_bottom_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && scrolled && (ROWS * COLUMNS <= 2048)) |->
        (32'(cursor_position) >= 32'((ROWS - 1) * COLUMNS)))
        else $error("scroll left cursor off the bottom row");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.valid)
        else $error("queue popped while empty");
`endif

endmodule
